>>> src/gdsc_pkg.sv
// ----------------------------------------------------------------------------
// gdsc_pkg
// Shared types, constants and calendar tables for the date/serial converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gdsc_pkg;

    // Register stages from the input handshake to the result register.
    localparam int NUM_STAGES = 7;
    // Stages inside each datapath; the stage after them is the shared result register.
    localparam int DP_STAGES  = NUM_STAGES - 1;

    localparam logic CMD_TO_SERIAL = 1'b0;
    localparam logic CMD_TO_DATE   = 1'b1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_MAR = 4'd3;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [5:0] JAN_LEN      = 6'd31;

    localparam logic [21:0] SERIAL_MAX = 22'd3652059;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;

    localparam logic [13:0] WINDOW_SPLIT = 14'd80;
    localparam logic [13:0] CENTURY_LEN  = 14'd100;
    localparam logic [13:0] BASE_2000    = 14'd2000;
    localparam logic [13:0] BASE_1900    = 14'd1900;
    localparam logic [8:0]  DAYS_YEAR    = 9'd365;
    localparam logic [6:0]  LAST_YEAR_IN_CENTURY = 7'd99;

    // x / 100 as (x * 5243) >> 19, exact for x below 43699.
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    // x / 365 as (x * 2941759) >> 30, exact for every 22-bit x.
    localparam logic [21:0] RECIP_365       = 22'd2941759;
    localparam int          RECIP_365_SHIFT = 30;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [13:0] in_year;
        logic [21:0] in_serial;
    } gdsc_item_t;

    typedef struct packed {
        logic [21:0] serial;
        logic [8:0]  day_of_year;
        logic [4:0]  month_length;
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        error;
    } gdsc_result_t;

    typedef struct packed {
        logic [21:0] serial;
        logic [8:0]  day_of_year;
        logic [4:0]  month_length;
        logic        error;
    } gdsc_d2s_t;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        error;
    } gdsc_s2d_t;

    // Days in the year before the first of the given month.
    function automatic logic [8:0] cum_before(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Length of the given month in a common year.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

    // Leap rule from the year's low bits, whether year % 100 is nonzero,
    // and the low bits of year / 100.
    function automatic logic leap_of(input logic [1:0] year_lo, input logic rem_nz,
                                     input logic [1:0] cent_lo);
        return (year_lo == 2'd0) && (rem_nz || (cent_lo == 2'd0));
    endfunction

endpackage

`default_nettype wire

>>> src/gdsc_if.sv
// ----------------------------------------------------------------------------
// gdsc_if
// Valid/ready channels for converter requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdsc_item_if import gdsc_pkg::*; ();
    logic       valid;
    logic       ready;
    gdsc_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdsc_result_if import gdsc_pkg::*; ();
    logic         valid;
    logic         ready;
    gdsc_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/gdsc_d2s.sv
// ----------------------------------------------------------------------------
// gdsc_d2s
// Date to serial datapath: windowing, century split, day sum, then hold.
// ----------------------------------------------------------------------------
`default_nettype none

module gdsc_d2s import gdsc_pkg::*;
(
    input  logic                 clk,
    input  logic [DP_STAGES:1]   en,
    input  logic [4:0]           in_day,
    input  logic [3:0]           in_month,
    input  logic [13:0]          in_year,
    output gdsc_d2s_t            res
);

    // Stage 1: year window and field checks.
    logic [13:0] year_win;
    logic        bad_s1;
    logic [4:0]  day1_reg;
    logic [3:0]  month1_reg;
    logic [13:0] year1_reg;
    logic        err1_reg;

    always_comb
    begin
        if (in_year < WINDOW_SPLIT)
        begin
            year_win = in_year + BASE_2000;
        end
        else if (in_year < CENTURY_LEN)
        begin
            year_win = in_year + BASE_1900;
        end
        else
        begin
            year_win = in_year;
        end
        bad_s1 = (in_day == 5'd0) || (in_month == 4'd0) || (in_month > MONTH_DEC)
                 || (year_win > YEAR_MAX);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            day1_reg   <= in_day;
            month1_reg <= in_month;
            year1_reg  <= year_win;
            err1_reg   <= bad_s1;
        end
    end

    // Stage 2: century by reciprocal and the whole-year day count.
    logic [26:0] cent_prod;
    logic [21:0] years_days;
    logic [4:0]  day2_reg;
    logic [3:0]  month2_reg;
    logic [13:0] year2_reg;
    logic [7:0]  cent2_reg;
    logic [21:0] ydays2_reg;
    logic [8:0]  cum2_reg;
    logic        err2_reg;

    always_comb
    begin
        cent_prod  = {13'd0, year1_reg} * {14'd0, RECIP_100};
        years_days = ({8'd0, year1_reg} - 22'd1) * {13'd0, DAYS_YEAR};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            day2_reg   <= day1_reg;
            month2_reg <= month1_reg;
            year2_reg  <= year1_reg;
            cent2_reg  <= cent_prod[RECIP_100_SHIFT +: 8];
            ydays2_reg <= years_days;
            cum2_reg   <= cum_before(month1_reg);
            err2_reg   <= err1_reg;
        end
    end

    // Stage 3: leap flag and the short part of the day sum.
    logic [14:0] cent_x100;
    logic        leap_s3;
    logic [11:0] part_s3;
    logic [8:0]  doy_s3;
    logic [11:0] part3_reg;
    logic [21:0] ydays3_reg;
    logic [3:0]  month3_reg;
    logic        leap3_reg;
    logic [8:0]  doy3_reg;
    logic [4:0]  len3_reg;
    logic        err3_reg;

    always_comb
    begin
        cent_x100 = {7'd0, cent2_reg} * 15'd100;
        leap_s3   = leap_of(year2_reg[1:0], {1'b0, year2_reg} != cent_x100, cent2_reg[1:0]);
        part_s3   = {7'd0, day2_reg} + {3'd0, cum2_reg} + 12'(year2_reg >> 2)
                    - {4'd0, cent2_reg} + {4'd0, cent2_reg >> 2};
        doy_s3    = {4'd0, day2_reg} - 9'd1 + cum2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            part3_reg  <= part_s3;
            ydays3_reg <= ydays2_reg;
            month3_reg <= month2_reg;
            leap3_reg  <= leap_s3;
            doy3_reg   <= doy_s3;
            len3_reg   <= month_len(month2_reg);
            err3_reg   <= err2_reg;
        end
    end

    // Stage 4: final serial, day of year and month length.
    gdsc_d2s_t res_next;
    gdsc_d2s_t res_reg [4:DP_STAGES];

    always_comb
    begin
        res_next.serial       = ydays3_reg + {10'd0, part3_reg}
                                - {21'd0, (month3_reg < MONTH_MAR) && leap3_reg};
        res_next.day_of_year  = doy3_reg + {8'd0, (month3_reg > MONTH_FEB) && leap3_reg};
        res_next.month_length = ((month3_reg == MONTH_FEB) && leap3_reg) ? FEB_LEAP_LEN
                                                                           : len3_reg;
        res_next.error        = 1'b0;
        if (err3_reg)
        begin
            res_next       = '0;
            res_next.error = 1'b1;
        end
    end

    // The remaining stages only hold the result so it lines up with the
    // longer serial-to-date path.
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            res_reg[4] <= res_next;
        end
        for (int k = 5; k <= DP_STAGES; k++)
        begin
            if (en[k])
            begin
                res_reg[k] <= res_reg[k-1];
            end
        end
    end

    assign res = res_reg[DP_STAGES];

endmodule

`default_nettype wire

>>> src/gdsc_s2d.sv
// ----------------------------------------------------------------------------
// gdsc_s2d
// Serial to date datapath: divide by 365, leap-day subtraction, year
// correction over two stages, month search and final adjustment.
// ----------------------------------------------------------------------------
`default_nettype none

module gdsc_s2d import gdsc_pkg::*;
(
    input  logic                 clk,
    input  logic [DP_STAGES:1]   en,
    input  logic [21:0]          in_serial,
    output gdsc_s2d_t            res
);

    localparam int STEPS_PER_STAGE = 4;

    typedef struct packed {
        logic [12:0] rem_days;   // two's complement, may be negative
        logic [13:0] year;
        logic [6:0]  cent;       // year / 100
        logic [6:0]  rem100;     // year % 100
    } loop_t;

    // One pass of the year correction: while the day count is negative,
    // borrow a whole year.
    function automatic loop_t fix_step(input loop_t s);
        loop_t n;
        logic  lp;
        n  = s;
        lp = leap_of(s.year[1:0], s.rem100 != 7'd0, s.cent[1:0]);
        if (s.rem_days[12] && (s.year != 14'd0))
        begin
            n.rem_days = s.rem_days + {4'd0, DAYS_YEAR} + {12'd0, lp};
            n.year     = s.year - 14'd1;
            if (s.rem100 == 7'd0)
            begin
                n.rem100 = LAST_YEAR_IN_CENTURY;
                n.cent   = s.cent - 7'd1;
            end
            else
            begin
                n.rem100 = s.rem100 - 7'd1;
            end
        end
        return n;
    endfunction

    // Stage 1: quotient by 365.
    logic [43:0] quot_prod;
    logic [21:0] serial1_reg;
    logic [13:0] quot1_reg;
    logic        err1_reg;

    assign quot_prod = {22'd0, in_serial} * {22'd0, RECIP_365};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            serial1_reg <= in_serial;
            quot1_reg   <= quot_prod[RECIP_365_SHIFT +: 14];
            err1_reg    <= in_serial > SERIAL_MAX;
        end
    end

    // Stage 2: remainder, year and century.
    logic [13:0] year_s2;
    logic [21:0] rem_full;
    logic [26:0] cent_prod;
    logic [8:0]  rem2_reg;
    logic [13:0] year2_reg;
    logic [6:0]  cent2_reg;
    logic        err2_reg;

    always_comb
    begin
        year_s2   = quot1_reg + 14'd1;
        rem_full  = serial1_reg - ({8'd0, quot1_reg} * {13'd0, DAYS_YEAR});
        cent_prod = {13'd0, year_s2} * {14'd0, RECIP_100};
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem2_reg  <= rem_full[8:0];
            year2_reg <= year_s2;
            cent2_reg <= cent_prod[RECIP_100_SHIFT +: 7];
            err2_reg  <= err1_reg;
        end
    end

    // Stage 3: subtract the leap days of all earlier years.
    logic [11:0] leap_days;
    logic [13:0] cent_x100;
    loop_t       loop_s3;
    loop_t       loop3_reg;
    logic        err3_reg;

    always_comb
    begin
        leap_days        = 12'(year2_reg >> 2) - {5'd0, cent2_reg} + {5'd0, cent2_reg >> 2};
        cent_x100        = {7'd0, cent2_reg} * 14'd100;
        loop_s3.rem_days = {4'd0, rem2_reg} - {1'b0, leap_days};
        loop_s3.year     = year2_reg;
        loop_s3.cent     = cent2_reg;
        loop_s3.rem100   = 7'(year2_reg - cent_x100);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            loop3_reg <= loop_s3;
            err3_reg  <= err2_reg;
        end
    end

    // Stages 4 and 5: four correction passes each; seven always suffice.
    loop_t loop_s4;
    loop_t loop_s5;
    loop_t loop4_reg;
    loop_t loop5_reg;
    logic  err4_reg;
    logic  err5_reg;

    always_comb
    begin
        loop_s4 = loop3_reg;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            loop_s4 = fix_step(loop_s4);
        end
        loop_s5 = loop4_reg;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            loop_s5 = fix_step(loop_s5);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            loop4_reg <= loop_s4;
            err4_reg  <= err3_reg;
        end
        if (en[5])
        begin
            loop5_reg <= loop_s5;
            err5_reg  <= err4_reg;
        end
    end

    // Stage 6: month search and day within month.
    logic [8:0] doy_s6;
    logic [3:0] month_s6;
    logic [8:0] dom_full;
    logic [5:0] day6_reg;
    logic [3:0] month6_reg;
    logic [13:0] year6_reg;
    logic       leap6_reg;
    logic       err6_reg;

    always_comb
    begin
        doy_s6   = loop5_reg.rem_days[8:0];
        month_s6 = MONTH_DEC;
        for (int k = 11; k >= 1; k--)
        begin
            if (doy_s6 <= cum_before(4'(k + 1)))
            begin
                month_s6 = 4'(k);
            end
        end
        dom_full = doy_s6 - cum_before(month_s6);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            day6_reg   <= dom_full[5:0];
            month6_reg <= month_s6;
            year6_reg  <= loop5_reg.year;
            leap6_reg  <= leap_of(loop5_reg.year[1:0], loop5_reg.rem100 != 7'd0,
                                  loop5_reg.cent[1:0]);
            err6_reg   <= err5_reg;
        end
    end

    // Final adjustment, registered in the shared result register.
    logic [5:0]  day_f;
    logic [3:0]  month_f;
    logic [13:0] year_f;

    always_comb
    begin
        day_f   = day6_reg;
        month_f = month6_reg;
        year_f  = year6_reg;
        if ((month_f <= MONTH_FEB) && leap6_reg)
        begin
            day_f = day_f + 6'd1;
            if ((month_f == MONTH_JAN) && (day_f > JAN_LEN))
            begin
                day_f   = 6'd1;
                month_f = MONTH_FEB;
            end
        end
        // A day count of zero is the last day of the previous year.
        if (day_f == 6'd0)
        begin
            year_f  = (year_f == 14'd0) ? 14'd0 : year_f - 14'd1;
            month_f = MONTH_DEC;
            day_f   = JAN_LEN;
        end
        res.out_day   = day_f[4:0];
        res.out_month = month_f;
        res.out_year  = year_f;
        res.error     = 1'b0;
        if (err6_reg)
        begin
            res       = '0;
            res.error = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> src/gregorian_date_serial_converter.sv
// ----------------------------------------------------------------------------
// gregorian_date_serial_converter
// Pipelined converter between proleptic Gregorian dates and day serials.
// ----------------------------------------------------------------------------
// The converter takes one transaction per clock unless a result-side stall
// has filled every stage, and returns results in order. The serial-to-date
// direction, whose whole-year correction takes two of the seven register
// stages (six of datapath, the last being the result register), sets the
// depth for both directions. A stall on the result side backs up stage by
// stage, so empty stages keep filling and up to seven transactions can be
// in flight. The block keeps no state between items.
`default_nettype none

module gregorian_date_serial_converter import gdsc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    gdsc_item_if.sink     item,
    gdsc_result_if.source result
);

    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] adv;
    logic                cmd_reg [1:DP_STAGES];
    gdsc_d2s_t           d2s_res;
    gdsc_s2d_t           s2d_res;
    gdsc_result_t        result_next;
    gdsc_result_t        result_reg;

    // A stage may load when it is empty or when the stage after it moves.
    always_comb
    begin
        adv[NUM_STAGES] = !valid_reg[NUM_STAGES] || result.ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign item.ready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= item.valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            cmd_reg[1] <= item.data.cmd;
        end
        for (int k = 2; k <= DP_STAGES; k++)
        begin
            if (adv[k])
            begin
                cmd_reg[k] <= cmd_reg[k-1];
            end
        end
    end

    gdsc_d2s u_d2s (
        .clk      (clk),
        .en       (adv[DP_STAGES:1]),
        .in_day   (item.data.in_day),
        .in_month (item.data.in_month),
        .in_year  (item.data.in_year),
        .res      (d2s_res)
    );

    gdsc_s2d u_s2d (
        .clk       (clk),
        .en        (adv[DP_STAGES:1]),
        .in_serial (item.data.in_serial),
        .res       (s2d_res)
    );

    always_comb
    begin
        result_next = '0;
        if (cmd_reg[DP_STAGES] == CMD_TO_DATE)
        begin
            result_next.out_day   = s2d_res.out_day;
            result_next.out_month = s2d_res.out_month;
            result_next.out_year  = s2d_res.out_year;
            result_next.error     = s2d_res.error;
        end
        else
        begin
            result_next.serial       = d2s_res.serial;
            result_next.day_of_year  = d2s_res.day_of_year;
            result_next.month_length = d2s_res.month_length;
            result_next.error        = d2s_res.error;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NUM_STAGES])
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid = valid_reg[NUM_STAGES];
    assign result.data  = result_reg;

endmodule

`default_nettype wire

>>> src/gdsc_checker.sv
// ----------------------------------------------------------------------------
// gdsc_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gdsc_checker import gdsc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_ready,
    input  logic         result_valid,
    input  logic         result_ready,
    input  gdsc_result_t result_data
);

    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = item_valid && item_ready;
    assign out_acc = result_valid && result_ready;

    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Every result must belong to an accepted transaction.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (cnt_reg != '0))
        else $error("result shown with no transaction in flight");

    // The pipeline never holds more transactions than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (cnt_reg < CNT_W'(NUM_STAGES)) || out_acc)
        else $error("transaction accepted into a full pipeline");

    a_error_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.error) |->
            (result_data.serial == '0) && (result_data.day_of_year == '0) &&
            (result_data.month_length == '0) && (result_data.out_day == '0) &&
            (result_data.out_month == '0) && (result_data.out_year == '0))
        else $error("error result carries nonzero fields");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result_data.serial == '0) && (result_data.day_of_year == '0) &&
             (result_data.month_length == '0)) ||
            ((result_data.out_day == '0) && (result_data.out_month == '0) &&
             (result_data.out_year == '0)))
        else $error("result mixes both conversion directions");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid && $stable(result_data))
        else $error("stalled result changed or dropped");

endmodule

bind gregorian_date_serial_converter gdsc_checker u_gdsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire
